/* rtl/slc_pkg.sv */
package slc_pkg;

  // recency rank storage and saturation
  localparam int RANK_W = 9;
  localparam logic [RANK_W-1:0] RANK_MAX = 9'd511;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_INDEX_BITS = 2'd0,
    REG_WAY_BITS   = 2'd1,
    REG_ALLOC      = 2'd2,
    REG_PREFETCH   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PF_NONE  = 2'd0,
    PF_ALL   = 2'd1,
    PF_MISS  = 2'd2,
    PF_SPARE = 2'd3
  } prefetch_t;

  // register file contents seen by the front and back
  typedef struct packed {
    logic [3:0] index_bits;
    logic [3:0] way_bits;
    logic       alloc_on_store;
    logic [1:0] prefetch_mode;
  } cfg_t;

endpackage

/* rtl/slc_if.sv */
interface slc_req_if #(parameter int ADDR_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [ADDR_WIDTH-1:0] address;
  logic                  is_store;
  modport source (output valid, address, is_store, input ready);
  modport sink (input valid, address, is_store, output ready);
endinterface

interface slc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] hit_count;
  modport source (output valid, hit, hit_count, input ready);
  modport sink (input valid, hit, hit_count, output ready);
endinterface

/* rtl/slc_ram.sv */
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/slc_front.sv */
module slc_front #(
  parameter int ADDR_WIDTH = 32,
  parameter int LINE_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  slc_req_if.sink               req,
  input  slc_pkg::cfg_t         cfg,
  input  logic                  clearing,
  output logic                  q_valid,
  output logic [ADDR_WIDTH-$clog2(LINE_BYTES)-1:0] q_line,
  output logic                  q_alloc,
  input  logic                  q_pop
);

  localparam int LSHIFT = $clog2(LINE_BYTES);
  localparam int LW = ADDR_WIDTH - LSHIFT;

  logic [LW-1:0] line_q [2];
  logic          alloc_q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  // accept while the queue has room and no clearing pass runs
  assign req.ready = (count != 2'd2) && !clearing;
  assign push = req.valid && req.ready;

  assign q_valid = (count != 2'd0);
  assign q_line  = line_q[rd_ptr];
  assign q_alloc = alloc_q[rd_ptr];

  // classify the request: line number and whether a miss allocates
  always_ff @(posedge clk) begin
    if (push) begin
      line_q[wr_ptr]  <= req.address[ADDR_WIDTH-1:LSHIFT];
      alloc_q[wr_ptr] <= !req.is_store || cfg.alloc_on_store;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/slc_back.sv */
module slc_back #(
  parameter int TOTAL_LINES = 1024,
  parameter int LINE_BYTES  = 32,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  slc_pkg::cfg_t         cfg,
  input  logic                  flush,
  output logic                  clearing,
  input  logic                  q_valid,
  input  logic [ADDR_WIDTH-$clog2(LINE_BYTES)-1:0] q_line,
  input  logic                  q_alloc,
  output logic                  q_pop,
  slc_rsp_if.source             rsp
);

  localparam int LSHIFT = $clog2(LINE_BYTES);
  localparam int LW     = ADDR_WIDTH - LSHIFT;
  localparam int IDXW   = $clog2(TOTAL_LINES);
  localparam int CNTW   = IDXW + 1;
  localparam int RW     = slc_pkg::RANK_W;
  localparam int EW     = 1 + RW + LW;
  localparam logic [3:0] CAP = 4'(IDXW);
  localparam logic [CNTW-1:0] LAST_LINE = CNTW'(TOTAL_LINES - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_CHK, S_URD, S_UWR, S_FIN, S_RES
  } state_t;

  state_t          state;
  logic [CNTW-1:0] cnt;
  logic [LW-1:0]   cur_line;
  logic            cur_alloc;
  logic            pf;
  logic            demand_hit;
  logic            hit_found;
  logic            empty_found;
  logic [IDXW-1:0] empty_way;
  logic [RW-1:0]   best_rank;
  logic [IDXW-1:0] best_way;
  logic [IDXW-1:0] upd_way;
  logic [RW-1:0]   old_rank;
  logic            fresh;
  logic [31:0]     hits;
  logic            rsp_valid;
  logic            rsp_hit;
  logic [31:0]     rsp_count;

  logic [3:0]      wb;
  logic [3:0]      ib;
  logic [IDXW-1:0] set_mask;
  logic [LW+IDXW-1:0] line_x;
  logic [IDXW-1:0] base;
  logic [LW-1:0]   tag;
  logic [CNTW-1:0] ways_m1;
  logic            last;
  logic [IDXW-1:0] cnt_i;

  logic [IDXW-1:0] ram_addr;
  logic            ram_we;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;

  logic            ent_valid;
  logic [RW-1:0]   ent_rank;
  logic [LW-1:0]   ent_tag;
  logic            ent_hit;
  logic            n_ef;
  logic [IDXW-1:0] n_ew;
  logic [RW-1:0]   n_br;
  logic [IDXW-1:0] n_bw;
  logic            inc;
  logic            go_pf;

  // clamped geometry
  assign wb = (cfg.way_bits > CAP) ? CAP : cfg.way_bits;
  assign ib = (cfg.index_bits > (CAP - wb)) ? (CAP - wb) : cfg.index_bits;

  // set base and tag of the line in work
  assign set_mask = (IDXW'(1) << ib) - IDXW'(1);
  assign line_x   = {{IDXW{1'b0}}, cur_line};
  assign base     = (line_x[IDXW-1:0] & set_mask) << wb;
  assign tag      = cur_line >> ib;
  assign ways_m1  = (CNTW'(1) << wb) - CNTW'(1);
  assign last     = (cnt == ways_m1);
  assign cnt_i    = cnt[IDXW-1:0];

  // entry fields
  assign ent_valid = ram_rdata[EW-1];
  assign ent_rank  = ram_rdata[LW +: RW];
  assign ent_tag   = ram_rdata[LW-1:0];
  assign ent_hit   = ent_valid && (ent_tag == tag);

  // running empty-way and victim selection including the current way
  assign n_ef = empty_found || !ent_valid;
  assign n_ew = empty_found ? empty_way : cnt_i;
  assign n_br = ((cnt == '0) || (ent_rank > best_rank)) ? ent_rank : best_rank;
  assign n_bw = ((cnt == '0) || (ent_rank > best_rank)) ? cnt_i : best_way;

  // recency aging of the other valid ways
  assign inc = ent_valid && (fresh || (ent_rank < old_rank)) &&
               (ent_rank != slc_pkg::RANK_MAX);

  assign go_pf = (cfg.prefetch_mode == slc_pkg::PF_ALL) ||
                 ((cfg.prefetch_mode == slc_pkg::PF_MISS) && !hit_found);

  // memory port
  always_comb begin
    ram_addr  = base + cnt_i;
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      S_CLR: begin
        ram_addr = cnt_i;
        ram_we   = 1'b1;
      end
      S_UWR: begin
        ram_we = 1'b1;
        if (cnt_i == upd_way) begin
          ram_wdata = {1'b1, {RW{1'b0}}, (fresh ? tag : ent_tag)};
        end else begin
          ram_wdata = {ent_valid, (inc ? ent_rank + RW'(1) : ent_rank), ent_tag};
        end
      end
      default: ;
    endcase
  end

  slc_ram #(.WIDTH(EW), .DEPTH(TOTAL_LINES)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign q_pop         = (state == S_IDLE) && q_valid;
  assign clearing      = (state == S_CLR);
  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.hit_count = rsp_count;

  // sequencer: clearing pass, search pass, update pass, prefetch, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      hits      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (flush || state != S_RES)) begin
        rsp_valid <= 1'b0;
      end
      if (flush) begin
        cnt   <= '0;
        state <= S_CLR;
      end else begin
        case (state)
          S_CLR: begin
            if (cnt == LAST_LINE) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + CNTW'(1);
            end
          end
          S_IDLE: begin
            if (q_valid) begin
              cur_line    <= q_line;
              cur_alloc   <= q_alloc;
              pf          <= 1'b0;
              hit_found   <= 1'b0;
              empty_found <= 1'b0;
              cnt         <= '0;
              state       <= S_RD;
            end
          end
          S_RD: state <= S_CHK;
          S_CHK: begin
            if (ent_hit) begin
              hit_found <= 1'b1;
              upd_way   <= cnt_i;
              old_rank  <= ent_rank;
              fresh     <= 1'b0;
              cnt       <= '0;
              state     <= S_URD;
            end else begin
              empty_found <= n_ef;
              empty_way   <= n_ew;
              best_rank   <= n_br;
              best_way    <= n_bw;
              if (last) begin
                if (!cur_alloc) begin
                  state <= S_FIN;
                end else begin
                  upd_way <= n_ef ? n_ew : n_bw;
                  fresh   <= 1'b1;
                  cnt     <= '0;
                  state   <= S_URD;
                end
              end else begin
                cnt   <= cnt + CNTW'(1);
                state <= S_RD;
              end
            end
          end
          S_URD: state <= S_UWR;
          S_UWR: begin
            if (last) begin
              state <= S_FIN;
            end else begin
              cnt   <= cnt + CNTW'(1);
              state <= S_URD;
            end
          end
          S_FIN: begin
            if (!pf) begin
              demand_hit <= hit_found;
              if (hit_found && (hits != '1)) begin
                hits <= hits + 32'd1;
              end
              if (go_pf) begin
                pf          <= 1'b1;
                cur_line    <= cur_line + LW'(1);
                cur_alloc   <= 1'b1;
                hit_found   <= 1'b0;
                empty_found <= 1'b0;
                cnt         <= '0;
                state       <= S_RD;
              end else begin
                state <= S_RES;
              end
            end else begin
              state <= S_RES;
            end
          end
          S_RES: begin
            if (!rsp_valid || rsp.ready) begin
              rsp_valid <= 1'b1;
              rsp_hit   <= demand_hit;
              rsp_count <= hits;
              state     <= S_IDLE;
            end
          end
          default: state <= S_CLR;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // the directory is written only by the clearing pass and the update pass
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_UWR))
    else $error("directory write outside clear or update");

  // way counter stays inside the set while searching and updating
  a_way_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK || state == S_UWR) |-> (cnt <= ways_m1))
    else $error("way counter past the set");

  // a demand hit bumps the hit counter by one
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !pf && hit_found && hits != '1 && !flush) |=>
      (hits == $past(hits) + 32'd1))
    else $error("hit counter missed a demand hit");

  // a new request is taken only after the result of the last one is queued
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && !rsp_valid && !flush) |=> (state == S_IDLE && rsp_valid))
    else $error("result not loaded");
`endif

endmodule

/* rtl/set_assoc_lru_cache_tags.sv */
// sequence: a lookup searches the set way by way, a read state and a check state
// per way, then on a hit or an allocating miss walks the set again to update the
// recency ranks, a read and a write state per way; a next-line prefetch may follow
// throughput: one request at a time; the single directory memory port sets it
// reset: synchronous, then a clearing pass over all TOTAL_LINES entries before the
// first request is taken; a write of index_bits or way_bits runs it again
module set_assoc_lru_cache_tags #(
  parameter int TOTAL_LINES = 1024,
  parameter int LINE_BYTES  = 32,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  slc_req_if.sink                      req,
  slc_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slc_pkg::PADDR_W-1:0]  paddr,
  input  logic [slc_pkg::PDATA_W-1:0]  pwdata,
  output logic [slc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int LW = ADDR_WIDTH - $clog2(LINE_BYTES);

  slc_pkg::cfg_t       cfg;
  slc_pkg::reg_index_t reg_sel;
  logic                wr_en;
  logic                flush;
  logic                clearing;
  logic                q_valid;
  logic [LW-1:0]       q_line;
  logic                q_alloc;
  logic                q_pop;

  assign pready  = 1'b1;
  assign reg_sel = slc_pkg::reg_index_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign flush   = wr_en && (reg_sel == slc_pkg::REG_INDEX_BITS ||
                             reg_sel == slc_pkg::REG_WAY_BITS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_bits     <= 4'd7;
      cfg.way_bits       <= 4'd2;
      cfg.alloc_on_store <= 1'b1;
      cfg.prefetch_mode  <= slc_pkg::PF_NONE;
    end else if (wr_en) begin
      case (reg_sel)
        slc_pkg::REG_INDEX_BITS: cfg.index_bits     <= pwdata[3:0];
        slc_pkg::REG_WAY_BITS:   cfg.way_bits       <= pwdata[3:0];
        slc_pkg::REG_ALLOC:      cfg.alloc_on_store <= pwdata[0];
        slc_pkg::REG_PREFETCH:   cfg.prefetch_mode  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      slc_pkg::REG_INDEX_BITS: prdata = {28'd0, cfg.index_bits};
      slc_pkg::REG_WAY_BITS:   prdata = {28'd0, cfg.way_bits};
      slc_pkg::REG_ALLOC:      prdata = {31'd0, cfg.alloc_on_store};
      slc_pkg::REG_PREFETCH:   prdata = {30'd0, cfg.prefetch_mode};
      default:                 prdata = '0;
    endcase
  end

  slc_front #(.ADDR_WIDTH(ADDR_WIDTH), .LINE_BYTES(LINE_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_line   (q_line),
    .q_alloc  (q_alloc),
    .q_pop    (q_pop)
  );

  slc_back #(
    .TOTAL_LINES (TOTAL_LINES),
    .LINE_BYTES  (LINE_BYTES),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .flush    (flush),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_line   (q_line),
    .q_alloc  (q_alloc),
    .q_pop    (q_pop),
    .rsp      (rsp)
  );

endmodule

/* tb/set_assoc_lru_cache_tags_tb.sv */
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_tb;

  localparam int LINES     = 1024;
  localparam int LOG_LINES = 10;
  localparam int LIMIT     = 4000000;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_count;
  } lookup_result_t;

  // tag directory tracker with its own copy of the registers
  class tag_directory;
    logic [26:0]                tags [LINES];
    bit                         valid [LINES];
    logic [slc_pkg::RANK_W-1:0] rank [LINES];
    logic [31:0]                hits;
    logic [3:0]                 index_bits;
    logic [3:0]                 way_bits;
    bit                         alloc_on_store;
    slc_pkg::prefetch_t         pf_mode;
    lookup_result_t             pending[$];
    int                         errors;

    function void reset_state();
      for (int i = 0; i < LINES; i++) begin
        tags[i] = '0;
      end
      clear_lines();
      hits = '0;
      index_bits = 4'd7;
      way_bits = 4'd2;
      alloc_on_store = 1'b1;
      pf_mode = slc_pkg::PF_NONE;
      errors = 0;
    endfunction

    function void clear_lines();
      for (int i = 0; i < LINES; i++) begin
        valid[i] = 1'b0;
        rank[i] = '0;
      end
    endfunction

    function int eff_ways_log();
      return (way_bits > LOG_LINES) ? LOG_LINES : way_bits;
    endfunction

    function int eff_index_log();
      int wb;
      wb = eff_ways_log();
      return (index_bits > LOG_LINES - wb) ? LOG_LINES - wb : index_bits;
    endfunction

    // move one way to most recent, aging the younger valid ways
    function void promote(int base, int ways, int w, bit fresh);
      int old;
      old = fresh ? 32'h7fffffff : int'(rank[base + w]);
      for (int i = 0; i < ways; i++) begin
        if (i != w && valid[base + i] && int'(rank[base + i]) < old &&
            rank[base + i] < slc_pkg::RANK_MAX) begin
          rank[base + i] = rank[base + i] + 1'b1;
        end
      end
      rank[base + w] = '0;
    endfunction

    function bit probe(logic [26:0] line, bit allocate);
      int wb, ib, ways, base, victim;
      logic [26:0] tag;
      logic [slc_pkg::RANK_W-1:0] best;
      bit empty_found;
      wb = eff_ways_log();
      ib = eff_index_log();
      ways = 1 << wb;
      tag = line >> ib;
      base = int'(line & ((27'd1 << ib) - 1)) << wb;
      for (int i = 0; i < ways; i++) begin
        if (valid[base + i] && tags[base + i] == tag) begin
          promote(base, ways, i, 1'b0);
          return 1'b1;
        end
      end
      if (!allocate) return 1'b0;
      victim = 0;
      empty_found = 1'b0;
      for (int i = 0; i < ways; i++) begin
        if (!empty_found && !valid[base + i]) begin
          victim = i;
          empty_found = 1'b1;
        end
      end
      if (!empty_found) begin
        best = '0;
        for (int i = 0; i < ways; i++) begin
          if (i == 0 || rank[base + i] > best) begin
            best = rank[base + i];
            victim = i;
          end
        end
      end
      tags[base + victim] = tag;
      valid[base + victim] = 1'b1;
      promote(base, ways, victim, 1'b1);
      return 1'b0;
    endfunction

    function void write_reg(slc_pkg::reg_index_t idx, logic [31:0] value);
      case (idx)
        slc_pkg::REG_INDEX_BITS: begin
          index_bits = value[3:0];
          clear_lines();
        end
        slc_pkg::REG_WAY_BITS: begin
          way_bits = value[3:0];
          clear_lines();
        end
        slc_pkg::REG_ALLOC: alloc_on_store = value[0];
        slc_pkg::REG_PREFETCH: pf_mode = slc_pkg::prefetch_t'(value[1:0]);
        default: ;
      endcase
    endfunction

    // accepted request: demand lookup, then optional next-line prefetch
    function void note_request(logic [31:0] address, bit is_store);
      logic [26:0] line;
      bit hit;
      lookup_result_t r;
      line = address[31:5];
      hit = probe(line, !is_store || alloc_on_store);
      if (hit && hits != 32'hffffffff) hits = hits + 1;
      if (pf_mode == slc_pkg::PF_ALL || (pf_mode == slc_pkg::PF_MISS && !hit)) begin
        void'(probe(line + 27'd1, 1'b1));
      end
      r.hit = hit;
      r.hit_count = hits;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic hit, logic [31:0] hit_count);
      lookup_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d count=%0d", hit, hit_count);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || hit_count !== e.hit_count) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected hit=%0d count=%0d, got hit=%0d count=%0d",
                   e.hit, e.hit_count, hit, hit_count);
        end
      end
    endfunction
  endclass

  typedef struct {
    int ib;
    int wb;
    int alloc;
    int pf;
    int count;
    int tag_span;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [slc_pkg::PADDR_W-1:0] paddr = '0;
  logic [slc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [slc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  slc_req_if #(.ADDR_WIDTH(32)) req_ch ();
  slc_rsp_if rsp_ch ();

  tag_directory dir;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int phase_no = 0;
  int sent_in_phase = 0;
  bit hold_off = 1'b0;

  set_assoc_lru_cache_tags u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.address = '0;
    req_ch.is_store = 1'b0;
    rsp_ch.ready = 1'b0;
    dir = new();
    dir.reset_state();
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // response side back pressure
  always @(negedge clk) begin
    if (hold_off) begin
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      dir.check_result(rsp_ch.hit, rsp_ch.hit_count);
    end
  end

  // long response stall while requests keep coming
  initial begin
    wait (phase_no == 4 && sent_in_phase >= 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  // one request; called at a falling edge, returns at a falling edge
  task automatic send_request(logic [31:0] address, bit is_store);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.address = address;
    req_ch.is_store = is_store;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    dir.note_request(address, is_store);
    sent_in_phase++;
    @(negedge clk);
  endtask

  task automatic write_reg(slc_pkg::reg_index_t idx, logic [31:0] value);
    req_ch.valid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = slc_pkg::PADDR_W'(4 * int'(idx));
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dir.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // wait for every result, then for a trailing prefetch to finish
  task automatic drain();
    req_ch.valid = 1'b0;
    while (dir.pending.size() != 0) @(negedge clk);
    repeat (8 * (1 << dir.eff_ways_log()) + 40) @(negedge clk);
  endtask

  // addresses drawn from a few sets and a limited tag range so hits occur
  function automatic logic [31:0] pick_address(int tag_span);
    logic [31:0] line;
    int ib, set_span;
    if ($urandom_range(99) < 8) return $urandom;
    ib = dir.eff_index_log();
    set_span = (ib > 2) ? 4 : (1 << ib);
    line = (32'($urandom_range(tag_span - 1)) << ib) |
           32'($urandom_range(set_span - 1) + ($urandom_range(1) ? 0 : (1 << ib) - set_span));
    if ($urandom_range(99) < 5) line = 32'h07ffffff - 32'($urandom_range(2));
    return {line[26:0], 5'($urandom)};
  endfunction

  phase_t phases [10];

  initial begin
    phases[0] = '{7, 2, 1, 0, 0, 0};
    phases[1] = '{7, 2, 1, 1, 250, 8};
    phases[2] = '{0, 0, 0, 2, 150, 3};
    phases[3] = '{10, 0, 1, 2, 200, 3};
    phases[4] = '{3, 4, 0, 1, 250, 24};
    phases[5] = '{0, 9, 1, 0, 8, 700};
    phases[6] = '{15, 15, 1, 1, 5, 1400};
    phases[7] = '{2, 3, 1, 3, 250, 12};
    phases[8] = '{6, 1, 0, 2, 250, 4};
    phases[9] = '{4, 2, 1, 1, 250, 6};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: field extremes, hits, store paths
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_001f, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
    send_request(32'hffff_ffe0, 1'b0);
    send_request(32'h0000_1000, 1'b1);
    send_request(32'h0000_1000, 1'b0);
    for (int i = 0; i < 5; i++) send_request(32'h0000_0000 + (i << 12), 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'haaaa_aaaa, 1'b1);
    send_request(32'h5555_5555, 1'b0);
    drain();
    // next line past the top wraps to line zero; no-allocate store miss
    write_reg(slc_pkg::REG_PREFETCH, 32'(slc_pkg::PF_ALL));
    write_reg(slc_pkg::REG_ALLOC, 32'd0);
    send_request(32'hffff_ffe5, 1'b0);
    send_request(32'h0000_0004, 1'b0);
    send_request(32'h0123_4560, 1'b1);
    send_request(32'h0123_4560, 1'b0);
    drain();

    for (int p = 1; p < 10; p++) begin
      phase_no = p;
      sent_in_phase = 0;
      write_reg(slc_pkg::REG_INDEX_BITS, phases[p].ib);
      write_reg(slc_pkg::REG_WAY_BITS, phases[p].wb);
      write_reg(slc_pkg::REG_ALLOC, phases[p].alloc);
      write_reg(slc_pkg::REG_PREFETCH, phases[p].pf);
      case (p % 3)
        1: begin
          send_idle = 17;
          recv_idle = 56;
        end
        2: begin
          send_idle = 56;
          recv_idle = 17;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int i = 0; i < phases[p].count; i++) begin
        send_request(pick_address(phases[p].tag_span), $urandom_range(99) < 30);
      end
      drain();
    end

    if (dir.pending.size() != 0) dir.errors += dir.pending.size();
    if (dir.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
